[src/window_distinct_counter_defines.svh]
// Assertion macros shared by the window distinct counter RTL.
// No dependencies; included by the files that carry assertions.
`ifndef WINDOW_DISTINCT_COUNTER_DEFINES_SVH
`define WINDOW_DISTINCT_COUNTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every edge outside reset.
`define WDC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("window_distinct_counter: check failed");
// Same-cycle implication.
`define WDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window_distinct_counter: implication failed");
// Next-cycle implication.
`define WDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("window_distinct_counter: sequence failed");
`else
`define WDC_ASSERT(lbl, clk, rst_n, prop)
`define WDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define WDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[src/wdc_pkg.sv]
// Shared constants and types for the window distinct counter.
// No dependencies; imported by every module of the block.
package wdc_pkg;

    // Defaults of the top-level parameters.
    localparam int WINDOW_MAX_DEF = 64;
    localparam int VALUE_BITS_DEF = 8;

    // Fixed field widths.
    localparam int SAMPLE_W   = 8;
    localparam int CFG_W      = 7;
    localparam int CNT_W      = 7;
    localparam int DATA_OUT_W = 8;

    // Output queue geometry.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Control group from the pipeline to the count table.
    typedef struct packed {
        logic clear;
        logic wr_en;
    } t_tbl_ctrl;

endpackage

[src/wdc_ring.sv]
// History ring: the last WINDOW_MAX values, one write and one read port.
// Depends on wdc_pkg.
module wdc_ring
    import wdc_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(WINDOW_MAX)-1:0] i_wr_addr,
    input  logic [VALUE_BITS-1:0]         i_wr_data,
    input  logic [$clog2(WINDOW_MAX)-1:0] i_rd_addr,
    output logic [VALUE_BITS-1:0]         o_rd_data
);

    logic [VALUE_BITS-1:0] r_mem [WINDOW_MAX];
    logic [VALUE_BITS-1:0] r_rd_data;

    // Read-first: a read of the slot being written returns the old value.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/wdc_count_mem.sv]
// Occurrence count table: two read ports, one write port, per-entry valid bits.
// Depends on wdc_pkg.
module wdc_count_mem
    import wdc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_tbl_ctrl             i_ctrl,
    input  logic [VALUE_BITS-1:0] i_wr_addr,
    input  logic [CNT_W-1:0]      i_wr_data,
    input  logic [VALUE_BITS-1:0] i_rd_addr_a,
    input  logic [VALUE_BITS-1:0] i_rd_addr_b,
    output logic [CNT_W-1:0]      o_cnt_a,
    output logic [CNT_W-1:0]      o_cnt_b
);

    localparam int DEPTH = 1 << VALUE_BITS;

    logic [CNT_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DEPTH-1:0] n_valid;
    logic [CNT_W-1:0] r_q_a;
    logic [CNT_W-1:0] r_q_b;
    logic             r_qv_a;
    logic             r_qv_b;

    // A clear wipes every entry at once; it also discards a write in the
    // same cycle, which always belongs to an earlier word.
    always_comb begin
        n_valid = r_valid;
        if (i_ctrl.clear) begin
            n_valid = '0;
        end else if (i_ctrl.wr_en) begin
            n_valid[i_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Synchronous reads with write-through bypass, so a read issued in the
    // cycle of a write to the same entry sees the new count.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q_a  <= (i_ctrl.wr_en && (i_wr_addr == i_rd_addr_a)) ? i_wr_data
                                                               : r_mem[i_rd_addr_a];
        r_q_b  <= (i_ctrl.wr_en && (i_wr_addr == i_rd_addr_b)) ? i_wr_data
                                                               : r_mem[i_rd_addr_b];
        r_qv_a <= n_valid[i_rd_addr_a];
        r_qv_b <= n_valid[i_rd_addr_b];
    end

    // An entry that is not live reads as zero.
    assign o_cnt_a = r_qv_a ? r_q_a : '0;
    assign o_cnt_b = r_qv_b ? r_q_b : '0;

endmodule

[src/wdc_out_fifo.sv]
// Small result queue between the update pipeline and the output stream.
// Depends on wdc_pkg and the assertion macro header.
`include "window_distinct_counter_defines.svh"
module wdc_out_fifo
    import wdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [CNT_W-1:0]     i_push_data,
    input  logic                 i_pop_ready,
    output logic                 o_valid,
    output logic [CNT_W-1:0]     o_data,
    output logic [OUT_CNT_W-1:0] o_count
);

    logic [CNT_W-1:0]     r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic                 w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && i_pop_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // The credit check upstream must never let the queue overflow.
    `WDC_ASSERT_IMPL(a_fifo_no_overflow, i_clk, i_rst_n, i_push && !w_pop, r_count != OUT_CNT_W'(OUT_DEPTH))

endmodule

[src/window_distinct_counter.sv]
// Top level of the sliding-window distinct value counter.
// Depends on wdc_pkg, wdc_ring, wdc_count_mem, wdc_out_fifo and the macro header.
//
//  Channel   Dir  Handshake              Content
//  s stream  in   i_s_tvalid/o_s_tready  tdata[7:0] sample_value, tuser start_sequence
//  m stream  out  o_m_tvalid/i_m_tready  tdata[6:0] distinct_count, tdata[7] zero
//  config    in   i_cfg_we               i_cfg_wdata window_size
//
// Words are never taken back to back: each one costs two writes to the
// single write port of the count table (the value leaving, then the value entering).
// An accepted word passes through stages 1, 2 and 3; its result enters the output queue from stage 3.
// Reset is synchronous; no clearing pass is needed, the count table has valid bits.
// A stalled output only holds the input off once the four-entry queue and the
// words in flight would fill it.
`include "window_distinct_counter_defines.svh"
module window_distinct_counter
    import wdc_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [SAMPLE_W-1:0]   i_s_tdata,   // [7:0] sample_value
    input  logic                  i_s_tuser,   // [0] start_sequence
    // Output stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [DATA_OUT_W-1:0] o_m_tdata,   // [6:0] distinct_count, [7] zero
    // Configuration.
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    localparam int PTR_W  = $clog2(WINDOW_MAX);
    localparam int SIZE_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = SIZE_W + 1;

    // Sequence control state.
    logic [SIZE_W-1:0]     r_size;
    logic [PTR_W-1:0]      r_wp;
    logic [SIZE_W-1:0]     r_fill;
    logic [CNT_W-1:0]      r_total;
    logic [CNT_W-1:0]      n_total;

    // Stage 1: ring data arrives, table reads issued.
    logic                  r_s1_vld;
    logic [VALUE_BITS-1:0] r_s1_val;
    logic                  r_s1_start;
    logic                  r_s1_has_old;
    logic                  r_s1_emit;
    // Stage 2: leaving value written back.
    logic                  r_s2_vld;
    logic [VALUE_BITS-1:0] r_s2_val;
    logic [VALUE_BITS-1:0] r_s2_old;
    logic                  r_s2_has_old;
    logic                  r_s2_emit;
    // Stage 3: entering value written back, result pushed.
    logic                  r_s3_vld;
    logic [VALUE_BITS-1:0] r_s3_val;
    logic [CNT_W-1:0]      r_s3_base;
    logic                  r_s3_emit;

    logic                  w_accept;
    logic [VALUE_BITS-1:0] w_val;
    logic [PTR_W-1:0]      w_wp_base;
    logic [SIZE_W-1:0]     w_fill_base;
    logic                  w_has_old;
    logic [SIZE_W-1:0]     w_fill_next;
    logic [SUM_W-1:0]      w_pos_sum;
    logic [PTR_W-1:0]      w_old_pos;
    logic [VALUE_BITS-1:0] w_ring_q;
    logic [CNT_W-1:0]      w_cnt_a;
    logic [CNT_W-1:0]      w_cnt_b;
    logic [CNT_W-1:0]      w_cnt_a_dec;
    logic                  w_s2_wr;
    logic [CNT_W-1:0]      w_s3_cnt;
    logic [CNT_W-1:0]      w_total_s3;
    logic                  w_clear;
    t_tbl_ctrl             w_tbl_ctrl;
    logic [VALUE_BITS-1:0] w_tbl_wr_addr;
    logic [CNT_W-1:0]      w_tbl_wr_data;
    logic                  w_push;
    logic                  w_fifo_valid;
    logic [CNT_W-1:0]      w_fifo_data;
    logic [OUT_CNT_W-1:0]  w_fifo_count;
    logic [OUT_CNT_W:0]    w_committed;
    logic [31:0]           w_cfg_ext;
    logic [SIZE_W-1:0]     w_cfg_size;

    // Only the low VALUE_BITS bits of a sample index the table.
    generate
        if (VALUE_BITS <= SAMPLE_W) begin : g_val_trunc
            assign w_val = i_s_tdata[VALUE_BITS-1:0];
        end else begin : g_val_ext
            assign w_val = VALUE_BITS'(i_s_tdata);
        end
    endgenerate

    // Window size written by configuration, held within 1..WINDOW_MAX.
    assign w_cfg_ext  = 32'(i_cfg_wdata);
    assign w_cfg_size = (w_cfg_ext == 32'd0)              ? SIZE_W'(1) :
                        (w_cfg_ext > 32'(WINDOW_MAX))     ? SIZE_W'(WINDOW_MAX) :
                                                            SIZE_W'(w_cfg_ext);

    // Admission: words never back to back, and room in the result queue
    // for every word already in flight.
    assign w_committed = (OUT_CNT_W + 1)'(w_fifo_count) + (OUT_CNT_W + 1)'(r_s2_vld)
                       + (OUT_CNT_W + 1)'(r_s3_vld);
    assign o_s_tready  = !r_s1_vld && (w_committed < (OUT_CNT_W + 1)'(OUT_DEPTH));
    assign w_accept    = i_s_tvalid && o_s_tready;

    // Window bookkeeping at acceptance; a start flag restarts the sequence.
    assign w_wp_base   = i_s_tuser ? '0 : r_wp;
    assign w_fill_base = i_s_tuser ? '0 : r_fill;
    assign w_has_old   = (w_fill_base >= r_size);
    assign w_fill_next = w_has_old ? w_fill_base : w_fill_base + 1'b1;

    // Slot of the value leaving the window.
    assign w_pos_sum = SUM_W'(w_wp_base) + SUM_W'(WINDOW_MAX) - SUM_W'(r_size);
    assign w_old_pos = (w_pos_sum >= SUM_W'(WINDOW_MAX)) ?
                       PTR_W'(w_pos_sum - SUM_W'(WINDOW_MAX)) : PTR_W'(w_pos_sum);

    wdc_ring #(
        .WINDOW_MAX (WINDOW_MAX),
        .VALUE_BITS (VALUE_BITS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept),
        .i_wr_addr (w_wp_base),
        .i_wr_data (w_val),
        .i_rd_addr (w_old_pos),
        .o_rd_data (w_ring_q)
    );

    // Table write port: stage 3 and stage 2 never fall in the same cycle.
    assign w_cnt_a_dec   = w_cnt_a - 1'b1;
    assign w_s2_wr       = r_s2_vld && r_s2_has_old && (w_cnt_a != '0);
    assign w_s3_cnt      = r_s3_base + 1'b1;
    assign w_clear       = (r_s1_vld && r_s1_start) || i_cfg_we;
    assign w_tbl_ctrl    = '{clear: w_clear, wr_en: w_s2_wr || r_s3_vld};
    assign w_tbl_wr_addr = r_s3_vld ? r_s3_val : r_s2_old;
    assign w_tbl_wr_data = r_s3_vld ? w_s3_cnt : w_cnt_a_dec;

    wdc_count_mem #(
        .VALUE_BITS (VALUE_BITS)
    ) u_count_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_tbl_ctrl),
        .i_wr_addr   (w_tbl_wr_addr),
        .i_wr_data   (w_tbl_wr_data),
        .i_rd_addr_a (w_ring_q),
        .i_rd_addr_b (r_s1_val),
        .o_cnt_a     (w_cnt_a),
        .o_cnt_b     (w_cnt_b)
    );

    // Distinct total: falls in stage 2, rises in stage 3, zeroed by a clear.
    assign w_total_s3 = (r_s3_vld && (w_s3_cnt == CNT_W'(1))) ? r_total + 1'b1 : r_total;

    always_comb begin
        n_total = w_total_s3;
        if (w_s2_wr && (w_cnt_a_dec == '0) && (r_total != '0)) begin
            n_total = r_total - 1'b1;
        end
        if (w_clear) begin
            n_total = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= SIZE_W'(1);
            r_wp     <= '0;
            r_fill   <= '0;
            r_total  <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_total  <= n_total;
            r_s1_vld <= w_accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            if (i_cfg_we) begin
                r_size <= w_cfg_size;
                r_wp   <= '0;
                r_fill <= '0;
            end else if (w_accept) begin
                r_wp   <= (w_wp_base == PTR_W'(WINDOW_MAX - 1)) ? '0 : w_wp_base + 1'b1;
                r_fill <= w_fill_next;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        r_s1_val     <= w_val;
        r_s1_start   <= i_s_tuser;
        r_s1_has_old <= w_has_old;
        r_s1_emit    <= (w_fill_next >= r_size);
        r_s2_val     <= r_s1_val;
        r_s2_old     <= w_ring_q;
        r_s2_has_old <= r_s1_has_old;
        r_s2_emit    <= r_s1_emit;
        r_s3_val     <= r_s2_val;
        // Entering value equal to the leaving one sees the fresh decrement.
        r_s3_base    <= (w_s2_wr && (r_s2_old == r_s2_val)) ? w_cnt_a_dec : w_cnt_b;
        r_s3_emit    <= r_s2_emit;
    end

    assign w_push = r_s3_vld && r_s3_emit;

    wdc_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_total_s3),
        .i_pop_ready (i_m_tready),
        .o_valid     (w_fifo_valid),
        .o_data      (w_fifo_data),
        .o_count     (w_fifo_count)
    );

    assign o_m_tvalid = w_fifo_valid;
    assign o_m_tdata  = DATA_OUT_W'(w_fifo_data);

    // The two table updates of neighbouring words must never collide.
    `WDC_ASSERT(a_single_tbl_write, i_clk, i_rst_n, !(w_s2_wr && r_s3_vld))
    // Acceptance drops the input ready, so words never arrive back to back.
    `WDC_ASSERT_NEXT(a_accept_spacing, i_clk, i_rst_n, w_accept, !o_s_tready)
    // The distinct total can never exceed the window it describes.
    `WDC_ASSERT(a_total_bounded, i_clk, i_rst_n, 32'(r_total) <= 32'(r_size))
    // A result always counts at least the value that just entered.
    `WDC_ASSERT_IMPL(a_result_nonzero, i_clk, i_rst_n, w_push, w_total_s3 != '0)

endmodule

[test/distinct_count_checker.sv]
`timescale 1ns / 1ps
// Checker for the window distinct counter. It watches the input, output and configuration ports,
// predicts each distinct count and compares it with the word the block sends.
// Depends on wdc_pkg for the port widths and the default table geometry.
module distinct_count_checker
    import wdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [SAMPLE_W-1:0]   i_s_tdata,    // [7:0] sample_value
    input  logic                  i_s_tuser,    // [0] start_sequence
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [DATA_OUT_W-1:0] i_m_tdata,    // [6:0] distinct_count, [7] zero
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int WIN_MAX = WINDOW_MAX_DEF;
    localparam int VALUES  = 1 << VALUE_BITS_DEF;
    localparam int SLOT_W  = $clog2(WIN_MAX);

    // Shadow copy of the block's state.
    logic [CFG_W-1:0]    window_reg;
    logic [SAMPLE_W-1:0] history [WIN_MAX];
    logic [SLOT_W-1:0]   next_slot;
    logic [6:0]          fill;
    logic [CNT_W-1:0]    occ_count [VALUES];
    logic                occ_live [VALUES];
    logic [CNT_W-1:0]    distinct_now;

    // Counts still owed by the block, oldest first.
    logic [CNT_W-1:0]    expected_counts [$];
    logic [CNT_W-1:0]    want;
    int                  fails = 0;
    int                  checked = 0;

    // A new sequence drops every count at once through the live bits.
    function void clear_history();
        for (int i = 0; i < VALUES; i++) begin
            occ_live[i] = 1'b0;
        end
        next_slot    = '0;
        fill         = '0;
        distinct_now = '0;
    endfunction

    // Zero behaves as one, anything past the ring depth as the full depth.
    function int window_in_use();
        int s;
        s = int'(window_reg);
        if (s == 0) begin
            s = 1;
        end
        if (s > WIN_MAX) begin
            s = WIN_MAX;
        end
        return s;
    endfunction

    function int count_of(input logic [SAMPLE_W-1:0] v);
        return occ_live[v] ? int'(occ_count[v]) : 0;
    endfunction

    // Updates the shadow state for one accepted word and queues its count, if any.
    function void take_sample(input logic [SAMPLE_W-1:0] v, input logic start);
        int size;
        int c;
        logic [SAMPLE_W-1:0] leaving;
        size = window_in_use();
        if (start) begin
            clear_history();
        end
        // The value that drops out of a full window gives back one occurrence.
        if (int'(fill) >= size) begin
            leaving = history[(int'(next_slot) + WIN_MAX - size) % WIN_MAX];
            c = count_of(leaving);
            if (c > 0) begin
                c--;
                occ_count[leaving] = CNT_W'(c);
                occ_live[leaving]  = 1'b1;
                if (c == 0 && distinct_now > 0) begin
                    distinct_now--;
                end
            end
        end
        // The arriving value adds one occurrence.
        c = count_of(v) + 1;
        occ_count[v] = CNT_W'(c);
        occ_live[v]  = 1'b1;
        if (c == 1) begin
            distinct_now++;
        end
        history[next_slot] = v;
        next_slot = (int'(next_slot) + 1 >= WIN_MAX) ? '0 : next_slot + 1'b1;
        if (int'(fill) < size) begin
            fill++;
        end
        if (int'(fill) >= size) begin
            expected_counts = {expected_counts, distinct_now};
        end
    endfunction

    // Configuration first, then the input word, then the output word of the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_reg = 7'd1;
            clear_history();
            expected_counts.delete();
        end else begin
            if (i_cfg_we) begin
                window_reg = i_cfg_wdata;
                clear_history();
            end
            if (i_s_tvalid && i_s_tready) begin
                take_sample(i_s_tdata, i_s_tuser);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_counts.size() == 0) begin
                    $error("distinct_count: word with no count expected, actual %0d",
                           i_m_tdata[CNT_W-1:0]);
                    fails++;
                end else begin
                    want = expected_counts.pop_front();
                    if (i_m_tdata[CNT_W-1:0] !== want) begin
                        $error("distinct_count: expected %0d, actual %0d",
                               want, i_m_tdata[CNT_W-1:0]);
                        fails++;
                    end
                    if (i_m_tdata[DATA_OUT_W-1:CNT_W] !== '0) begin
                        $error("tdata pad: expected 0, actual %0d",
                               i_m_tdata[DATA_OUT_W-1:CNT_W]);
                        fails++;
                    end
                    checked++;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_counts.size();
        o_checked    <= checked;
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Top of the window distinct counter testbench: clock, reset, stimulus and the verdict.
// Depends on wdc_pkg, the window_distinct_counter RTL and distinct_count_checker.
module testbench;
    import wdc_pkg::*;

    localparam int PHASES      = 14;
    localparam int PHASE_WORDS = 136;
    localparam int CYCLE_LIMIT = 500000;
    // Comfortably beyond the latency of the block.
    localparam int SETTLE      = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  s_valid;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_data;      // [7:0] sample_value
    logic                  s_user;      // [0] start_sequence
    logic                  m_valid;
    logic                  m_ready;
    logic [DATA_OUT_W-1:0] m_data;      // [6:0] distinct_count, [7] zero
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_wdata;

    int fail_count;
    int pending;
    int checked;
    int cycles = 0;
    int words_sent = 0;
    int cfg_writes = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    window_distinct_counter uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    distinct_count_checker count_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_user),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: after each word taken it holds tready low for a random stretch.
    initial begin
        int hold;
        bit took;
        hold = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge clk);
            took = m_valid && m_ready && rst_n;
            @(negedge clk);
            if (took) begin
                hold = rx_calm ? 0 : $urandom_range(0, 5);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offers one word after a random gap and returns at the edge that takes it.
    task automatic send_word(input logic [SAMPLE_W-1:0] value, input logic start);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            s_data  <= SAMPLE_W'($urandom);
            s_user  <= 1'(($urandom));
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= value;
        s_user  <= start;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        words_sent++;
    endtask

    // The register is only written once the block has drained.
    task automatic set_window(input logic [CFG_W-1:0] size);
        @(negedge clk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    // Stimulus: a directed opening, then phases of random sequences per window setting.
    initial begin
        int size;
        int len;
        int mode;
        int alpha;
        int step_val;
        int done;
        logic [SAMPLE_W-1:0] v;

        rst_n     = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        s_user    = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // The reset window holds one value, so every word counts as one.
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h55, 1'b1);
        send_word(8'hAA, 1'b0);
        send_word(8'hFF, 1'b0);

        // Window of three: repeats, and a new sequence started part-way, twice.
        set_window(7'd3);
        send_word(8'd7, 1'b0);
        send_word(8'd7, 1'b0);
        send_word(8'd7, 1'b0);
        send_word(8'd8, 1'b0);
        send_word(8'd9, 1'b0);
        send_word(8'd200, 1'b1);
        send_word(8'd201, 1'b0);
        send_word(8'd200, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h80, 1'b1);
        send_word(8'h01, 1'b0);
        send_word(8'h01, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: size = 0;
                1: size = 1;
                2: size = 2;
                3: size = 64;
                4: size = 65;
                5: size = 127;
                6: size = 63;
                default: begin
                    size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(1, 64);
                end
            endcase
            set_window(CFG_W'(size));
            if (size == 0) begin
                size = 1;
            end
            if (size > WINDOW_MAX_DEF) begin
                size = WINDOW_MAX_DEF;
            end

            // Mostly sequences long enough to fill and slide the window, a few cut short.
            done = 0;
            while (done < PHASE_WORDS) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, size)
                                                  : $urandom_range(size, 3 * size);
                mode     = $urandom_range(0, 3);
                alpha    = $urandom_range(1, 8);
                step_val = $urandom_range(0, 255);
                tx_calm  = ($urandom_range(0, 3) == 0);
                rx_calm  = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < len && done < PHASE_WORDS; i++) begin
                    case (mode)
                        0: v = SAMPLE_W'($urandom_range(0, 255));
                        // A handful of values, so counts climb well above one.
                        1: v = SAMPLE_W'(step_val + $urandom_range(0, alpha - 1));
                        // Rising values: a full window of distinct entries.
                        2: begin
                            step_val = step_val + $urandom_range(1, 3);
                            v = SAMPLE_W'(step_val);
                        end
                        default: v = SAMPLE_W'(step_val);
                    endcase
                    send_word(v, (i == 0) ? 1'b1 : ($urandom_range(0, 29) == 0));
                    done++;
                end
            end
        end

        // Drain and give the verdict.
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        @(negedge clk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (2 * SETTLE) @(posedge clk);
        $display("Sent %0d words across %0d register writes, window settings 0 to 127.",
                 words_sent, cfg_writes);
        $display("Compared %0d distinct counts, %0d failures.", checked, fail_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/wdc_pkg.sv
src/wdc_ring.sv
src/wdc_count_mem.sv
src/wdc_out_fifo.sv
src/window_distinct_counter.sv
test/distinct_count_checker.sv
test/testbench.sv
